FILE: design/assert_macros.svh
// Assertion helpers shared by the design files.
// Both macros sample on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/sbfd_pkg.sv
`timescale 1ns / 1ps

package sbfd_pkg;

  // Frame layout
  localparam int FRAME_LEN   = 25;
  localparam int POS_W       = $clog2(FRAME_LEN);
  localparam int STORE_BYTES = 15;                    // header plus channel bytes 1..14
  localparam int PACK_W      = 8 * (STORE_BYTES - 1);
  localparam logic [7:0] FRAME_HEADER = 8'h0F;
  localparam logic [7:0] FRAME_FOOTER = 8'h00;

  // Channel layout
  localparam int RAW_W    = 11;
  localparam int CHAN_W   = 12;
  localparam int NUM_CHAN = 6;
  localparam int NUM_STICK = 4;
  localparam int NUM_SW   = 4;
  localparam int SW_W     = 2;
  localparam logic signed [CHAN_W-1:0] SW_LOW_LEVEL = 12'sd783;

  // Configuration register widths and reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WD_W       = 8;
  localparam logic [RAW_W-1:0] CENTER_RST  = 11'd1024;
  localparam logic [RAW_W-1:0] LIMIT_RST   = 11'd784;
  localparam logic [WD_W-1:0]  TIMEOUT_RST = 8'd20;
  localparam logic [WD_W-1:0]  STARTUP_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_OFFSET = 2'd0,
    CFG_STICK_LIMIT   = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2,
    CFG_STARTUP_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [SW_W-1:0] {
    SW_CLEARED = 2'd0,
    SW_HIGH    = 2'd1,
    SW_LOW     = 2'd2,
    SW_MIDDLE  = 2'd3
  } sw_code_e;

  // One accepted input request
  typedef struct packed {
    logic       frame_start;
    cmd_e       cmd;
    logic [7:0] data_byte;
  } item_t;

  // Frame buffer status toward the core
  typedef struct packed {
    logic done;     // this byte completes a frame
    logic hdr_ok;
    logic ftr_ok;
  } frame_stat_t;

  // Unpacked frame contents
  typedef struct packed {
    logic [NUM_SW-1:0][SW_W-1:0]     sw;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
    logic                            sticks_ok;
  } dec_t;

endpackage

FILE: design/sbfd_frame_buf.sv
`timescale 1ns / 1ps

module sbfd_frame_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,          // a byte request is processed
  input  logic [7:0]                  data_byte_i,
  input  logic                        frame_start_i,
  output sbfd_pkg::frame_stat_t       stat_o,
  output logic [sbfd_pkg::PACK_W-1:0] bytes_o        // frame bytes 1..14, byte 1 lowest
);

  localparam logic [sbfd_pkg::POS_W-1:0] LAST_POS =
    sbfd_pkg::POS_W'(sbfd_pkg::FRAME_LEN - 1);
  localparam logic [sbfd_pkg::POS_W-1:0] STORE_END =
    sbfd_pkg::POS_W'(sbfd_pkg::STORE_BYTES);

  logic [sbfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [sbfd_pkg::POS_W-1:0] wr_pos;
  logic                       wr_en;
  logic [7:0]                 buf_q [sbfd_pkg::STORE_BYTES];

  // Byte position: a start byte opens a frame, the last byte closes it
  always_comb begin
    pos_d  = pos_q;
    wr_pos = frame_start_i ? '0 : pos_q;
    wr_en  = 1'b0;
    if (en_i) begin
      if (frame_start_i) begin
        wr_en = 1'b1;
        pos_d = sbfd_pkg::POS_W'(1);
      end else if (pos_q != '0) begin
        wr_en = 1'b1;
        pos_d = (pos_q == LAST_POS) ? '0 : pos_q + sbfd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Only the header and channel bytes are kept
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sbfd_pkg::STORE_BYTES; i++) begin
      if (wr_en && wr_pos < STORE_END && wr_pos == sbfd_pkg::POS_W'(i)) begin
        buf_q[i] <= data_byte_i;
      end
    end
  end

  always_comb begin
    for (int i = 1; i < sbfd_pkg::STORE_BYTES; i++) begin
      bytes_o[(i-1)*8 +: 8] = buf_q[i];
    end
  end

  // Footer is the byte in flight
  assign stat_o.done   = en_i && !frame_start_i && (pos_q == LAST_POS);
  assign stat_o.hdr_ok = (buf_q[0] == sbfd_pkg::FRAME_HEADER);
  assign stat_o.ftr_ok = (data_byte_i == sbfd_pkg::FRAME_FOOTER);

endmodule

FILE: design/sbfd_decode.sv
`timescale 1ns / 1ps

module sbfd_decode (
  input  logic [sbfd_pkg::PACK_W-1:0] bytes_i,
  input  logic [sbfd_pkg::RAW_W-1:0]  center_i,
  input  logic [sbfd_pkg::RAW_W-1:0]  limit_i,
  output sbfd_pkg::dec_t              dec_o
);

  logic signed [sbfd_pkg::CHAN_W-1:0] cent [sbfd_pkg::NUM_CHAN + sbfd_pkg::NUM_SW];
  logic [sbfd_pkg::CHAN_W-1:0]        mag  [sbfd_pkg::NUM_STICK];
  logic [sbfd_pkg::NUM_STICK-1:0]     in_lim;

  // Eleven-bit channels packed LSB first, centred
  always_comb begin
    for (int i = 0; i < sbfd_pkg::NUM_CHAN + sbfd_pkg::NUM_SW; i++) begin
      cent[i] = $signed({1'b0, bytes_i[i*sbfd_pkg::RAW_W +: sbfd_pkg::RAW_W]})
              - $signed({1'b0, center_i});
    end
  end

  // Stick magnitude check
  always_comb begin
    for (int i = 0; i < sbfd_pkg::NUM_STICK; i++) begin
      mag[i]    = cent[i][sbfd_pkg::CHAN_W-1] ? -cent[i] : cent[i];
      in_lim[i] = (mag[i] <= {1'b0, limit_i});
    end
  end

  always_comb begin
    for (int i = 0; i < sbfd_pkg::NUM_CHAN; i++) begin
      dec_o.chan[i] = cent[i];
    end
    // Switch levels: zero is middle, the low level is low, anything else high
    for (int i = 0; i < sbfd_pkg::NUM_SW; i++) begin
      if (cent[sbfd_pkg::NUM_CHAN + i] == '0) begin
        dec_o.sw[i] = sbfd_pkg::SW_MIDDLE;
      end else if (cent[sbfd_pkg::NUM_CHAN + i] == sbfd_pkg::SW_LOW_LEVEL) begin
        dec_o.sw[i] = sbfd_pkg::SW_LOW;
      end else begin
        dec_o.sw[i] = sbfd_pkg::SW_HIGH;
      end
    end
    dec_o.sticks_ok = &in_lim;
  end

endmodule

FILE: design/sbus_frame_decoder_with_link_watchdog_core.sv
// Path: a tick or frame-closing byte is held in the input register, then registered in
// the result register, which raises m_axis_tvalid; a full result slot can hold it back.
// Throughput: one request per cycle; while a result waits on m_axis_tready the input
// register takes one more request and then s_axis_tready drops until the result goes.
// Reset (rst_ni, async low): config to defaults, link offline, data cleared,
// watchdog loaded with the default startup count, no frame open.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sbus_frame_decoder_with_link_watchdog_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config write port
  input  logic                              cfg_we_i,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // data_byte
  input  logic [1:0]                        s_axis_tuser,  // cmd, frame_start
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // right_stick_h, right_stick_v, left_stick_v, left_stick_h, left_knob,
  // right_knob (12 each), sw_a, sw_b, sw_c, sw_d (2 each)
  output logic [79:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser   // frame_ok, link_online
);

  localparam int CH_BITS = sbfd_pkg::NUM_CHAN * sbfd_pkg::CHAN_W;
  localparam int SW_BITS = sbfd_pkg::NUM_SW * sbfd_pkg::SW_W;

  // Config registers
  logic [sbfd_pkg::RAW_W-1:0] center_q, limit_q;
  logic [sbfd_pkg::WD_W-1:0]  timeout_q;

  // Input stage
  sbfd_pkg::item_t in_q;
  logic            in_valid_q;
  logic            advance;
  logic            is_tick;
  logic            fb_en;

  // Link state
  logic [sbfd_pkg::NUM_CHAN-1:0][sbfd_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic [sbfd_pkg::NUM_SW-1:0][sbfd_pkg::SW_W-1:0]     sw_q, sw_d;
  logic                                                valid_q, valid_d;
  logic                                                online_q, online_d;
  logic [sbfd_pkg::WD_W-1:0]                           wd_q, wd_d;

  // Result stage
  logic                     out_valid_q, out_valid_d;
  logic [CH_BITS+SW_BITS-1:0] res_data_q;
  logic [1:0]               res_user_q;
  logic                     produce;

  sbfd_pkg::frame_stat_t      fstat;
  logic [sbfd_pkg::PACK_W-1:0] fbytes;
  sbfd_pkg::dec_t             dec;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= sbfd_pkg::CENTER_RST;
      limit_q   <= sbfd_pkg::LIMIT_RST;
      timeout_q <= sbfd_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (sbfd_pkg::cfg_idx_e'(cfg_idx_i))
        sbfd_pkg::CFG_CENTER_OFFSET: center_q  <= cfg_data_i[sbfd_pkg::RAW_W-1:0];
        sbfd_pkg::CFG_STICK_LIMIT:   limit_q   <= cfg_data_i[sbfd_pkg::RAW_W-1:0];
        sbfd_pkg::CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[sbfd_pkg::WD_W-1:0];
        sbfd_pkg::CFG_STARTUP_TICKS: ;  // loads the watchdog below
      endcase
    end
  end

  // Input register; the request moves on when the result slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign is_tick       = (in_q.cmd == sbfd_pkg::CMD_TICK);
  assign fb_en         = advance && !is_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.data_byte   <= s_axis_tdata;
      in_q.cmd         <= sbfd_pkg::cmd_e'(s_axis_tuser[0]);
      in_q.frame_start <= s_axis_tuser[1];
    end
  end

  sbfd_frame_buf u_frame_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fb_en),
    .data_byte_i   (in_q.data_byte),
    .frame_start_i (in_q.frame_start),
    .stat_o        (fstat),
    .bytes_o       (fbytes)
  );

  sbfd_decode u_decode (
    .bytes_i  (fbytes),
    .center_i (center_q),
    .limit_i  (limit_q),
    .dec_o    (dec)
  );

  // Watchdog and frame acceptance
  always_comb begin
    chan_d   = chan_q;
    sw_d     = sw_q;
    valid_d  = valid_q;
    online_d = online_q;
    wd_d     = wd_q;
    if (advance && is_tick) begin
      if (wd_q != '0) begin
        wd_d = wd_q - sbfd_pkg::WD_W'(1);
      end else begin
        online_d = 1'b0;
        chan_d   = '0;
        sw_d     = '0;
      end
    end else if (fstat.done && fstat.hdr_ok && fstat.ftr_ok) begin
      chan_d = dec.chan;
      sw_d   = dec.sw;
      if (!dec.sticks_ok) begin
        valid_d = 1'b0;
      end else begin
        valid_d = 1'b1;
        if (sbfd_pkg::sw_code_e'(dec.sw[0]) != sbfd_pkg::SW_HIGH) begin
          wd_d     = timeout_q;
          online_d = 1'b1;
        end else begin
          chan_d = '0;
          sw_d   = '0;
        end
      end
    end
    // Startup count write reloads the watchdog
    if (cfg_we_i && sbfd_pkg::cfg_idx_e'(cfg_idx_i) == sbfd_pkg::CFG_STARTUP_TICKS) begin
      wd_d = cfg_data_i[sbfd_pkg::WD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q   <= '0;
      sw_q     <= '0;
      valid_q  <= 1'b0;
      online_q <= 1'b0;
      wd_q     <= sbfd_pkg::STARTUP_RST;
    end else begin
      chan_q   <= chan_d;
      sw_q     <= sw_d;
      valid_q  <= valid_d;
      online_q <= online_d;
      wd_q     <= wd_d;
    end
  end

  // Result register: ticks and closed frames give a result
  assign produce = advance && (is_tick || fstat.done);

  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      res_data_q <= {sw_d, chan_d};
      res_user_q <= {online_d, valid_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_data_q;
  assign m_axis_tuser  = res_user_q;

  // A held request stays in the input register
  `ASSERT_RST(a_in_held, in_valid_q && !advance |=> in_valid_q && $stable(in_q),
              "input request lost while stalled")
  // A tick always yields a result
  `ASSERT_RST(a_tick_result, advance && is_tick |=> out_valid_q,
              "tick gave no result")
  // An expired watchdog drops the link and clears the data
  `ASSERT_RST(a_expire,
              advance && is_tick && wd_q == '0 |=> !online_q && chan_q == '0 && sw_q == '0,
              "watchdog expiry did not clear the link")

endmodule
